/* rtl/gusf_pkg.sv */
// Shared types and constants for the grammar useless symbol finder.
package gusf_pkg;

    localparam int unsigned SYM_COUNT = 26;
    localparam int unsigned SYM_W     = 5;
    localparam int unsigned ENTRY_W   = SYM_W + SYM_COUNT;

    typedef logic [SYM_COUNT-1:0] t_mask;
    typedef logic [SYM_W-1:0]     t_sym;
    typedef logic [ENTRY_W-1:0]   t_entry;

    typedef struct packed {
        logic load;
        logic init_gen;
        logic init_reach;
        logic apply_gen;
        logic apply_reach;
        logic clr_changed;
        logic rd_en;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic changed;
        logic out_free;
    } t_sts;

endpackage

/* rtl/gusf_ctrl.sv */
// Sequencer for production load, fixpoint passes and result hand-off.
module gusf_ctrl #(
    parameter int unsigned CW = 9,
    parameter int unsigned AW = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_in_last,
    output logic              o_in_ready,
    input  logic [CW-1:0]     i_count,
    input  gusf_pkg::t_sts    i_sts,
    output gusf_pkg::t_cmd    o_cmd,
    output logic [AW-1:0]     o_rd_addr
);

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_GEN   = 4'b0010,
        S_REACH = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_pend, n_pend;

    assign o_in_ready = (r_state == S_LOAD);
    assign o_rd_addr  = r_idx[AW-1:0];

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pend  = 1'b0;
        o_cmd   = '0;
        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_in_last) begin
                        o_cmd.init_gen = 1'b1;
                        n_idx          = '0;
                        n_state        = S_GEN;
                    end
                end
            end
            S_GEN: begin
                o_cmd.apply_gen = r_pend;
                if (r_idx < i_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CW'(1);
                    n_pend      = 1'b1;
                end else if (!r_pend) begin
                    n_idx = '0;
                    if (i_sts.changed) begin
                        o_cmd.clr_changed = 1'b1;
                    end else begin
                        o_cmd.init_reach = 1'b1;
                        n_state          = S_REACH;
                    end
                end
            end
            S_REACH: begin
                o_cmd.apply_reach = r_pend;
                if (r_idx < i_count) begin
                    o_cmd.rd_en = 1'b1;
                    n_idx       = r_idx + CW'(1);
                    n_pend      = 1'b1;
                end else if (!r_pend) begin
                    n_idx = '0;
                    if (i_sts.changed) begin
                        o_cmd.clr_changed = 1'b1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pend  <= n_pend;
        end
    end

endmodule

/* rtl/gusf_dp.sv */
// Production store, symbol sets and result register.
module gusf_dp #(
    parameter int unsigned MAX_PRODUCTIONS = 256,
    parameter int unsigned CW = 9,
    parameter int unsigned AW = 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  gusf_pkg::t_cmd           i_cmd,
    output gusf_pkg::t_sts           o_sts,
    output logic [CW-1:0]            o_count,
    input  logic [AW-1:0]            i_rd_addr,
    input  gusf_pkg::t_entry         i_entry,
    input  logic                     i_cfg_valid,
    input  gusf_pkg::t_sym           i_cfg_data,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output gusf_pkg::t_mask          o_out_mask,
    output logic                     o_out_ovf
);

    gusf_pkg::t_entry r_mem [MAX_PRODUCTIONS];
    gusf_pkg::t_entry r_rd_data;
    logic [CW-1:0]    r_count;
    gusf_pkg::t_mask  r_appears, r_gen, r_reach;
    logic             r_ovf, r_changed, r_out_valid;
    gusf_pkg::t_sym   r_start;

    gusf_pkg::t_sym   in_lhs, rd_lhs;
    gusf_pkg::t_mask  in_rhs, rd_rhs, rd_bit, in_bit;
    logic             in_ok, full;

    assign in_lhs = i_entry[gusf_pkg::ENTRY_W-1:gusf_pkg::SYM_COUNT];
    assign in_rhs = i_entry[gusf_pkg::SYM_COUNT-1:0];
    assign in_bit = gusf_pkg::SYM_COUNT'(1) << in_lhs;
    assign in_ok  = (in_lhs < gusf_pkg::SYM_W'(gusf_pkg::SYM_COUNT));
    assign full   = (r_count == CW'(MAX_PRODUCTIONS));
    assign rd_lhs = r_rd_data[gusf_pkg::ENTRY_W-1:gusf_pkg::SYM_COUNT];
    assign rd_rhs = r_rd_data[gusf_pkg::SYM_COUNT-1:0];
    assign rd_bit = gusf_pkg::SYM_COUNT'(1) << rd_lhs;

    assign o_count        = r_count;
    assign o_sts.changed  = r_changed;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid    = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load && in_ok && !full) begin
            r_mem[r_count[AW-1:0]] <= i_entry;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_out_mask <= r_appears & ~(r_reach & r_gen);
            o_out_ovf  <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_appears   <= '0;
            r_gen       <= '0;
            r_reach     <= '0;
            r_ovf       <= 1'b0;
            r_changed   <= 1'b0;
            r_out_valid <= 1'b0;
            r_start     <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_start <= i_cfg_data;
            end
            if (i_cmd.load && in_ok) begin
                if (!full) begin
                    r_count   <= r_count + CW'(1);
                    r_appears <= r_appears | in_bit | in_rhs;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.init_gen) begin
                r_gen     <= '0;
                r_changed <= 1'b0;
            end
            if (i_cmd.init_reach) begin
                r_reach   <= (r_start < gusf_pkg::SYM_W'(gusf_pkg::SYM_COUNT)) ?
                             (gusf_pkg::SYM_COUNT'(1) << r_start) : '0;
                r_changed <= 1'b0;
            end
            if (i_cmd.clr_changed) begin
                r_changed <= 1'b0;
            end
            if (i_cmd.apply_gen) begin
                if (((r_gen & rd_bit) == '0) && ((rd_rhs & ~r_gen) == '0)) begin
                    r_gen     <= r_gen | rd_bit;
                    r_changed <= 1'b1;
                end
            end
            if (i_cmd.apply_reach) begin
                if (((r_reach & rd_bit) != '0) && ((r_reach | rd_rhs) != r_reach)) begin
                    r_reach   <= r_reach | rd_rhs;
                    r_changed <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
                r_count     <= '0;
                r_appears   <= '0;
                r_ovf       <= 1'b0;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

/* rtl/grammar_useless_symbol_finder.sv */
// Top level: finds unreachable or non-generating nonterminals of a grammar.
// Load: one production word per cycle; a word with tlast starts the computation.
// Compute: each fixpoint repeats passes over the P stored entries until a pass changes nothing (one pass if empty);
//   the result becomes valid once the generating fixpoint and then the reaching fixpoint have both settled.
// The result register frees the input for the next grammar while a result waits.
// Reset: synchronous active low; clears count, sets, flags and start_symbol.
module grammar_useless_symbol_finder #(
    parameter int unsigned MAX_PRODUCTIONS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // lhs_index[4:0], rhs_mask[30:5], zero pad
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // useless_mask[25:0], zero pad
    output logic        m_axis_tuser,   // overflow
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data      // start_symbol
);

    localparam int unsigned CW = $clog2(MAX_PRODUCTIONS + 1);
    localparam int unsigned AW = (MAX_PRODUCTIONS > 1) ? $clog2(MAX_PRODUCTIONS) : 1;

    gusf_pkg::t_cmd  cmd;
    gusf_pkg::t_sts  sts;
    logic [CW-1:0]   count;
    logic [AW-1:0]   rd_addr;
    gusf_pkg::t_mask out_mask;
    logic            in_ready;

    assign s_axis_tready = in_ready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tdata  = {6'b0, out_mask};

    gusf_ctrl #(
        .CW (CW),
        .AW (AW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (in_ready),
        .i_count    (count),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr)
    );

    gusf_dp #(
        .MAX_PRODUCTIONS (MAX_PRODUCTIONS),
        .CW              (CW),
        .AW              (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_count     (count),
        .i_rd_addr   (rd_addr),
        .i_entry     ({s_axis_tdata[gusf_pkg::SYM_W-1:0],
                       s_axis_tdata[gusf_pkg::SYM_W +: gusf_pkg::SYM_COUNT]}),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_mask  (out_mask),
        .o_out_ovf   (m_axis_tuser)
    );

endmodule

/* rtl/gusf_checker.sv */
// Port-level checks for the grammar useless symbol finder, bound to the top level.
module gusf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result word changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_last_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input ready while computing");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
        else $error("result without a finished computation");

endmodule

bind grammar_useless_symbol_finder gusf_checker u_gusf_checker (.*);
